// File: src/bdpb_pkg.sv
// Shared types, constants and helpers for the brush dab pixel blend pipeline.
package bdpb_pkg;

    localparam logic [16:0] ONE_Q16    = 17'h10000;
    localparam logic [15:0] MIN_RADIUS = 16'd26;

    localparam logic [2:0] CFG_CENTER_X  = 3'd0;
    localparam logic [2:0] CFG_CENTER_Y  = 3'd1;
    localparam logic [2:0] CFG_RADIUS    = 3'd2;
    localparam logic [2:0] CFG_OPACITY   = 3'd3;
    localparam logic [2:0] CFG_HARDNESS  = 3'd4;
    localparam logic [2:0] CFG_PAINT_R   = 3'd5;
    localparam logic [2:0] CFG_PAINT_G   = 3'd6;
    localparam logic [2:0] CFG_PAINT_B   = 3'd7;

    typedef struct packed {
        logic [16:0] red;
        logic [16:0] green;
        logic [16:0] blue;
        logic [16:0] alpha;
    } t_pix;

    function automatic logic [16:0] sat_q16(input logic [16:0] v);
        sat_q16 = (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

endpackage

// File: src/bdpb_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband payload.
module bdpb_div
    import bdpb_pkg::*;
#(
    parameter int RW = 32,
    parameter int QB = 17,
    parameter int SW = 69
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [RW-1:0] i_rem,
    input  logic [QB-1:0] i_low,
    input  logic [RW-1:0] i_div,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QB-1:0] o_quot,
    output logic [SW-1:0] o_side
);

    logic          r_vld  [QB];
    logic [RW-1:0] r_rem  [QB];
    logic [QB-1:0] r_low  [QB];
    logic [QB-1:0] r_quot [QB];
    logic [RW-1:0] r_dvs  [QB];
    logic [SW-1:0] r_side [QB];

    genvar k;
    generate
        for (k = 0; k < QB; k++) begin : g_stage
            logic          p_vld;
            logic [RW-1:0] p_rem;
            logic [QB-1:0] p_low;
            logic [QB-1:0] p_quot;
            logic [RW-1:0] p_dvs;
            logic [SW-1:0] p_side;
            logic [RW:0]   w_trial;
            logic [RW:0]   w_diff;
            logic          w_ge;

            if (k == 0) begin : g_first
                assign p_vld  = i_valid;
                assign p_rem  = i_rem;
                assign p_low  = i_low;
                assign p_quot = '0;
                assign p_dvs  = i_div;
                assign p_side = i_side;
            end else begin : g_next
                assign p_vld  = r_vld[k-1];
                assign p_rem  = r_rem[k-1];
                assign p_low  = r_low[k-1];
                assign p_quot = r_quot[k-1];
                assign p_dvs  = r_dvs[k-1];
                assign p_side = r_side[k-1];
            end

            assign w_trial = {p_rem, p_low[QB-1]};
            assign w_ge    = w_trial >= {1'b0, p_dvs};
            assign w_diff  = w_trial - {1'b0, p_dvs};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else begin
                    r_vld[k] <= p_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                r_rem[k]  <= w_ge ? w_diff[RW-1:0] : w_trial[RW-1:0];
                r_low[k]  <= {p_low[QB-2:0], 1'b0};
                r_quot[k] <= {p_quot[QB-2:0], w_ge};
                r_dvs[k]  <= p_dvs;
                r_side[k] <= p_side;
            end
        end
    endgenerate

    assign o_valid = r_vld[QB-1];
    assign o_quot  = r_quot[QB-1];
    assign o_side  = r_side[QB-1];

endmodule

// File: src/bdpb_geom.sv
// Distance stages: offsets, clipping, squares and inside test.
module bdpb_geom
    import bdpb_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [COORD_BITS-1:0] i_px,
    input  logic [COORD_BITS-1:0] i_py,
    input  t_pix                  i_pix,
    input  logic signed [24:0]    i_center_x,
    input  logic signed [24:0]    i_center_y,
    input  logic [15:0]           i_radius,
    input  logic                  i_enable,
    output logic                  o_valid,
    output logic [32:0]           o_d2,
    output logic [31:0]           o_r2,
    output logic                  o_inside,
    output t_pix                  o_pix
);

    localparam int PW = COORD_BITS + 8;
    localparam int DW = ((PW > 25) ? PW : 25) + 2;

    logic signed [DW-1:0] w_dx;
    logic signed [DW-1:0] w_dy;
    logic signed [DW-1:0] w_ndx;
    logic signed [DW-1:0] w_ndy;

    logic          r_vld_a;
    logic [DW-2:0] r_ax;
    logic [DW-2:0] r_ay;
    logic          r_en;
    t_pix          r_pix_a;

    logic          w_far;
    logic          r_vld_b;
    logic [31:0]   r_sqx;
    logic [31:0]   r_sqy;
    logic [31:0]   r_r2_b;
    logic          r_near;
    t_pix          r_pix_b;

    logic [32:0]   w_d2;

    assign w_dx = $signed({{(DW-PW){1'b0}}, i_px, 8'h80})
                - $signed({{(DW-25){i_center_x[24]}}, i_center_x});
    assign w_dy = $signed({{(DW-PW){1'b0}}, i_py, 8'h80})
                - $signed({{(DW-25){i_center_y[24]}}, i_center_y});
    assign w_ndx = -w_dx;
    assign w_ndy = -w_dy;

    assign w_far = (r_ax > {{(DW-17){1'b0}}, i_radius})
                || (r_ay > {{(DW-17){1'b0}}, i_radius});

    assign w_d2 = {1'b0, r_sqx} + {1'b0, r_sqy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a  <= 1'b0;
            r_vld_b  <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_vld_a  <= i_valid;
            r_vld_b  <= r_vld_a;
            o_valid  <= r_vld_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ax          <= w_dx[DW-1] ? w_ndx[DW-2:0] : w_dx[DW-2:0];
        r_ay          <= w_dy[DW-1] ? w_ndy[DW-2:0] : w_dy[DW-2:0];
        r_en          <= i_enable;
        r_pix_a.red   <= sat_q16(i_pix.red);
        r_pix_a.green <= sat_q16(i_pix.green);
        r_pix_a.blue  <= sat_q16(i_pix.blue);
        r_pix_a.alpha <= sat_q16(i_pix.alpha);

        r_sqx   <= r_ax[15:0] * r_ax[15:0];
        r_sqy   <= r_ay[15:0] * r_ay[15:0];
        r_r2_b  <= i_radius * i_radius;
        r_near  <= r_en && !w_far;
        r_pix_b <= r_pix_a;

        o_d2     <= w_d2;
        o_r2     <= r_r2_b;
        o_inside <= r_near && (w_d2 <= {1'b0, r_r2_b});
        o_pix    <= r_pix_b;
    end

endmodule

// File: src/bdpb_falloff.sv
// Hardness falloff: case select, numerator product, shared divider, falloff value.
module bdpb_falloff
    import bdpb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [16:0] i_rr,
    input  t_pix        i_pix,
    input  logic        i_inside,
    input  logic [16:0] i_hard,
    output logic        o_valid,
    output logic [16:0] o_f,
    output t_pix        o_pix,
    output logic        o_inside
);

    typedef struct packed {
        t_pix        pix;
        logic        in_dab;
        logic        flat;
        logic        case_a;
        logic [16:0] rr;
    } t_fside;

    logic        r_vld;
    logic [16:0] r_rr;
    logic [31:0] r_num;
    logic        r_case_a;
    logic        r_flat;
    t_pix        r_pix;
    logic        r_inside;

    logic [33:0] w_prod;
    logic [16:0] w_rem;
    logic [15:0] w_low;
    logic [16:0] w_dvs;
    t_fside      w_side_in;
    t_fside      w_side_out;
    logic        w_div_vld;
    logic [15:0] w_quot;
    logic [17:0] w_soft;
    logic [17:0] w_f;

    assign w_prod = i_hard * (ONE_Q16 - i_rr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rr     <= i_rr;
        r_num    <= w_prod[31:0];
        r_case_a <= i_rr < i_hard;
        r_flat   <= i_hard == ONE_Q16;
        r_pix    <= i_pix;
        r_inside <= i_inside;
    end

    assign w_rem = r_case_a ? r_rr : {1'b0, r_num[31:16]};
    assign w_low = r_case_a ? 16'd0 : r_num[15:0];
    assign w_dvs = r_case_a ? i_hard : ONE_Q16 - i_hard;

    assign w_side_in.pix    = r_pix;
    assign w_side_in.in_dab = r_inside;
    assign w_side_in.flat   = r_flat;
    assign w_side_in.case_a = r_case_a;
    assign w_side_in.rr     = r_rr;

    bdpb_div #(
        .RW (17),
        .QB (16),
        .SW ($bits(t_fside))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld),
        .i_rem   (w_rem),
        .i_low   (w_low),
        .i_div   (w_dvs),
        .i_side  (w_side_in),
        .o_valid (w_div_vld),
        .o_quot  (w_quot),
        .o_side  (w_side_out)
    );

    assign w_soft = {1'b0, w_side_out.rr} + {1'b0, ONE_Q16} - {2'b00, w_quot};
    assign w_f    = w_side_out.flat   ? {1'b0, ONE_Q16} :
                    w_side_out.case_a ? w_soft : {2'b00, w_quot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_f      <= (w_f > {1'b0, ONE_Q16}) ? ONE_Q16 : w_f[16:0];
        o_pix    <= w_side_out.pix;
        o_inside <= w_side_out.in_dab;
    end

endmodule

// File: src/bdpb_blend.sv
// Opacity scaling and premultiplied over composite.
module bdpb_blend
    import bdpb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [16:0] i_f,
    input  t_pix        i_pix,
    input  logic        i_inside,
    input  logic [16:0] i_opacity,
    input  logic [16:0] i_paint_r,
    input  logic [16:0] i_paint_g,
    input  logic [16:0] i_paint_b,
    output logic        o_valid,
    output t_pix        o_pix,
    output logic        o_touched
);

    logic        r_vld_g;
    logic [16:0] r_opa;
    t_pix        r_pix_g;
    logic        r_inside_g;

    logic        r_vld_h;
    logic [16:0] r_top_r;
    logic [16:0] r_top_g;
    logic [16:0] r_top_b;
    logic [16:0] r_old_r;
    logic [16:0] r_old_g;
    logic [16:0] r_old_b;
    logic [16:0] r_old_a;
    logic [16:0] r_opa_h;
    t_pix        r_pix_h;
    logic        r_inside_h;

    logic [33:0] w_opa_p;
    logic [16:0] w_inv;
    logic [33:0] w_tr;
    logic [33:0] w_tg;
    logic [33:0] w_tb;
    logic [33:0] w_or;
    logic [33:0] w_og;
    logic [33:0] w_ob;
    logic [33:0] w_oa;

    assign w_opa_p = i_opacity * i_f;

    assign w_inv = ONE_Q16 - r_opa;
    assign w_tr  = i_paint_r * r_opa;
    assign w_tg  = i_paint_g * r_opa;
    assign w_tb  = i_paint_b * r_opa;
    assign w_or  = w_inv * r_pix_g.red;
    assign w_og  = w_inv * r_pix_g.green;
    assign w_ob  = w_inv * r_pix_g.blue;
    assign w_oa  = w_inv * r_pix_g.alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_g <= 1'b0;
            r_vld_h <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_vld_g <= i_valid;
            r_vld_h <= r_vld_g;
            o_valid <= r_vld_h;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opa      <= w_opa_p[32:16];
        r_pix_g    <= i_pix;
        r_inside_g <= i_inside;

        r_top_r    <= w_tr[32:16];
        r_top_g    <= w_tg[32:16];
        r_top_b    <= w_tb[32:16];
        r_old_r    <= w_or[32:16];
        r_old_g    <= w_og[32:16];
        r_old_b    <= w_ob[32:16];
        r_old_a    <= w_oa[32:16];
        r_opa_h    <= r_opa;
        r_pix_h    <= r_pix_g;
        r_inside_h <= r_inside_g;

        if (r_inside_h) begin
            o_pix.red   <= r_top_r + r_old_r;
            o_pix.green <= r_top_g + r_old_g;
            o_pix.blue  <= r_top_b + r_old_b;
            o_pix.alpha <= r_opa_h + r_old_a;
        end else begin
            o_pix <= r_pix_h;
        end
        o_touched <= r_inside_h;
    end

endmodule

// File: src/brush_dab_pixel_blend_top.sv
// Brush dab pixel blend: configuration registers and the full pixel pipeline.
// Throughput: one pixel per cycle outside reset; the two 16/17-stage dividers are fully pipelined.
// busy is high only while reset is asserted; the receiver cannot stall results.
// Synchronous active-low reset clears valid bits and sets the configuration registers to defaults.
module brush_dab_pixel_blend_top
    import bdpb_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_BITS-1:0] i_pixel_x,
    input  logic [COORD_BITS-1:0] i_pixel_y,
    input  logic [16:0]           i_old_red,
    input  logic [16:0]           i_old_green,
    input  logic [16:0]           i_old_blue,
    input  logic [16:0]           i_old_alpha,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [24:0]           i_cfg_data,
    output logic                  o_valid,
    output logic [16:0]           o_new_red,
    output logic [16:0]           o_new_green,
    output logic [16:0]           o_new_blue,
    output logic [16:0]           o_new_alpha,
    output logic                  o_touched
);

    typedef struct packed {
        t_pix pix;
        logic in_dab;
    } t_rr_side;

    logic signed [24:0] r_center_x;
    logic signed [24:0] r_center_y;
    logic [15:0]        r_radius;
    logic [16:0]        r_opacity;
    logic [16:0]        r_hardness;
    logic [16:0]        r_paint_r;
    logic [16:0]        r_paint_g;
    logic [16:0]        r_paint_b;

    logic [16:0] w_op;
    logic [16:0] w_hard;
    logic        w_enable;
    logic        w_accept;
    t_pix        w_pix_in;

    logic        w_geo_vld;
    logic [32:0] w_d2;
    logic [31:0] w_r2;
    logic        w_geo_inside;
    t_pix        w_geo_pix;
    t_rr_side    w_rr_side_in;
    t_rr_side    w_rr_side_out;

    logic        w_rr_vld;
    logic [16:0] w_rr;

    logic        w_f_vld;
    logic [16:0] w_f;
    t_pix        w_f_pix;
    logic        w_f_inside;

    t_pix        w_out_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_radius   <= '0;
            r_opacity  <= '0;
            r_hardness <= ONE_Q16;
            r_paint_r  <= '0;
            r_paint_g  <= '0;
            r_paint_b  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CENTER_X: r_center_x <= $signed(i_cfg_data);
                CFG_CENTER_Y: r_center_y <= $signed(i_cfg_data);
                CFG_RADIUS:   r_radius   <= i_cfg_data[15:0];
                CFG_OPACITY:  r_opacity  <= i_cfg_data[16:0];
                CFG_HARDNESS: r_hardness <= i_cfg_data[16:0];
                CFG_PAINT_R:  r_paint_r  <= i_cfg_data[16:0];
                CFG_PAINT_G:  r_paint_g  <= i_cfg_data[16:0];
                CFG_PAINT_B:  r_paint_b  <= i_cfg_data[16:0];
                default: begin
                end
            endcase
        end
    end

    assign busy     = ~i_rst_n;
    assign w_accept = start && !busy;

    assign w_op     = sat_q16(r_opacity);
    assign w_hard   = sat_q16(r_hardness);
    assign w_enable = (w_op != 17'd0) && (w_hard != 17'd0) && (r_radius >= MIN_RADIUS);

    assign w_pix_in.red   = i_old_red;
    assign w_pix_in.green = i_old_green;
    assign w_pix_in.blue  = i_old_blue;
    assign w_pix_in.alpha = i_old_alpha;

    bdpb_geom #(
        .COORD_BITS (COORD_BITS)
    ) u_geom (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_accept),
        .i_px       (i_pixel_x),
        .i_py       (i_pixel_y),
        .i_pix      (w_pix_in),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_radius   (r_radius),
        .i_enable   (w_enable),
        .o_valid    (w_geo_vld),
        .o_d2       (w_d2),
        .o_r2       (w_r2),
        .o_inside   (w_geo_inside),
        .o_pix      (w_geo_pix)
    );

    assign w_rr_side_in.pix    = w_geo_pix;
    assign w_rr_side_in.in_dab = w_geo_inside;

    bdpb_div #(
        .RW (32),
        .QB (17),
        .SW ($bits(t_rr_side))
    ) u_rr_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_geo_vld),
        .i_rem   (w_d2[32:1]),
        .i_low   ({w_d2[0], 16'd0}),
        .i_div   (w_r2),
        .i_side  (w_rr_side_in),
        .o_valid (w_rr_vld),
        .o_quot  (w_rr),
        .o_side  (w_rr_side_out)
    );

    bdpb_falloff u_falloff (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_rr_vld),
        .i_rr     (w_rr),
        .i_pix    (w_rr_side_out.pix),
        .i_inside (w_rr_side_out.in_dab),
        .i_hard   (w_hard),
        .o_valid  (w_f_vld),
        .o_f      (w_f),
        .o_pix    (w_f_pix),
        .o_inside (w_f_inside)
    );

    bdpb_blend u_blend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_f_vld),
        .i_f       (w_f),
        .i_pix     (w_f_pix),
        .i_inside  (w_f_inside),
        .i_opacity (w_op),
        .i_paint_r (sat_q16(r_paint_r)),
        .i_paint_g (sat_q16(r_paint_g)),
        .i_paint_b (sat_q16(r_paint_b)),
        .o_valid   (o_valid),
        .o_pix     (w_out_pix),
        .o_touched (o_touched)
    );

    assign o_new_red   = w_out_pix.red;
    assign o_new_green = w_out_pix.green;
    assign o_new_blue  = w_out_pix.blue;
    assign o_new_alpha = w_out_pix.alpha;

endmodule

// File: tb/tb_brush_dab_pixel_blend_top.sv
// Testbench for brush_dab_pixel_blend_top: directed and random pixels checked against table rows or a dab predictor.
`timescale 1ns / 100ps

module tb_brush_dab_pixel_blend_top
    import bdpb_pkg::*;
();

    localparam int RUN_LIMIT    = 400000;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_PIXELS = 160;
    localparam int N_DIR        = 25;

    typedef struct {
        logic [24:0] cx;
        logic [24:0] cy;
        logic [15:0] rad;
        logic [16:0] opac;
        logic [16:0] hard;
        logic [16:0] pr;
        logic [16:0] pg;
        logic [16:0] pb;
    } t_dab_cfg;

    typedef struct {
        t_pix pix;
        logic touched;
    } t_dab_result;

    typedef struct {
        int          cfg;
        logic [15:0] x;
        logic [15:0] y;
        t_pix        old;
        bit          known;
        t_pix        want;
        logic        want_touched;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic        busy;
    logic [15:0] i_pixel_x   = '0;
    logic [15:0] i_pixel_y   = '0;
    logic [16:0] i_old_red   = '0;
    logic [16:0] i_old_green = '0;
    logic [16:0] i_old_blue  = '0;
    logic [16:0] i_old_alpha = '0;
    logic        i_cfg_we    = 1'b0;
    logic [2:0]  i_cfg_idx   = '0;
    logic [24:0] i_cfg_data  = '0;
    logic        o_valid;
    logic [16:0] o_new_red;
    logic [16:0] o_new_green;
    logic [16:0] o_new_blue;
    logic [16:0] o_new_alpha;
    logic        o_touched;

    t_dab_result pending_pixels [$];
    t_dab_cfg    dab;
    int          errors      = 0;
    int unsigned cycle_count = 0;

    t_dab_cfg dir_cfgs [11] = '{
        '{25'd0, 25'd0, 16'd0, 17'd0, 17'd65536, 17'd0, 17'd0, 17'd0},
        '{25'd2688, 25'd2688, 16'd1024, 17'd65536, 17'd65536, 17'd65536, 17'd0, 17'd32768},
        '{25'd2688, 25'd2688, 16'd25, 17'd65536, 17'd65536, 17'd65536, 17'd0, 17'd32768},
        '{25'd2688, 25'd2688, 16'd26, 17'd65536, 17'd65536, 17'd65536, 17'd0, 17'd32768},
        '{25'd2688, 25'd2688, 16'd1024, 17'd65536, 17'd0, 17'd65536, 17'd0, 17'd32768},
        '{25'd2688, 25'd2688, 16'd1024, 17'd0, 17'd65536, 17'd65536, 17'd0, 17'd32768},
        '{25'd2688, 25'd2688, 16'd1024, 17'h1FFFF, 17'd32768, 17'h1FFFF, 17'd40000,
          17'h1FFFF},
        '{25'd2688, 25'd2688, 16'd1024, 17'd30000, 17'd1, 17'd10000, 17'd20000, 17'd30000},
        '{25'd2688, 25'd2688, 16'd1024, 17'd65535, 17'd65535, 17'd65536, 17'd65535, 17'd0},
        '{25'h0FFFFFF, 25'h0FFFFFF, 16'd65535, 17'd65536, 17'h1FFFF, 17'd12345, 17'd0,
          17'd65536},
        '{25'h1800000, 25'h1800000, 16'd65535, 17'd65536, 17'd65536, 17'd1, 17'd2, 17'd3}
    };

    t_dir_row dir_rows [N_DIR] = '{
        '{0, 16'd5, 16'd5, '{17'h1FFFF, 17'd0, 17'd65536, 17'h10001}, 1'b1,
          '{17'd65536, 17'd0, 17'd65536, 17'd65536}, 1'b0},
        '{0, 16'd65535, 16'd65535, '{17'd1, 17'd2, 17'd3, 17'd4}, 1'b1,
          '{17'd1, 17'd2, 17'd3, 17'd4}, 1'b0},
        '{1, 16'd10, 16'd10, '{17'd0, 17'd0, 17'd0, 17'd0}, 1'b1,
          '{17'd65536, 17'd0, 17'd32768, 17'd65536}, 1'b1},
        '{1, 16'd10, 16'd10, '{17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF}, 1'b1,
          '{17'd65536, 17'd0, 17'd32768, 17'd65536}, 1'b1},
        '{1, 16'd14, 16'd10, '{17'd100, 17'd200, 17'd300, 17'd400}, 1'b1,
          '{17'd65536, 17'd0, 17'd32768, 17'd65536}, 1'b1},
        '{1, 16'd15, 16'd10, '{17'd100, 17'd200, 17'd300, 17'd400}, 1'b1,
          '{17'd100, 17'd200, 17'd300, 17'd400}, 1'b0},
        '{1, 16'd13, 16'd13, '{17'd100, 17'd200, 17'd300, 17'd400}, 1'b0, '{0, 0, 0, 0}, 1'b0},
        '{1, 16'd12, 16'd11, '{17'd30000, 17'd1, 17'd65536, 17'd40000}, 1'b0,
          '{0, 0, 0, 0}, 1'b0},
        '{2, 16'd10, 16'd10, '{17'd100, 17'd200, 17'd300, 17'd400}, 1'b1,
          '{17'd100, 17'd200, 17'd300, 17'd400}, 1'b0},
        '{3, 16'd10, 16'd10, '{17'd100, 17'd200, 17'd300, 17'd400}, 1'b1,
          '{17'd65536, 17'd0, 17'd32768, 17'd65536}, 1'b1},
        '{3, 16'd11, 16'd10, '{17'd100, 17'd200, 17'd300, 17'd400}, 1'b1,
          '{17'd100, 17'd200, 17'd300, 17'd400}, 1'b0},
        '{4, 16'd10, 16'd10, '{17'd100, 17'd200, 17'd300, 17'd400}, 1'b1,
          '{17'd100, 17'd200, 17'd300, 17'd400}, 1'b0},
        '{5, 16'd10, 16'd10, '{17'd100, 17'd200, 17'd300, 17'd400}, 1'b1,
          '{17'd100, 17'd200, 17'd300, 17'd400}, 1'b0},
        '{6, 16'd10, 16'd10, '{17'd20000, 17'd40000, 17'd60000, 17'd65536}, 1'b0,
          '{0, 0, 0, 0}, 1'b0},
        '{6, 16'd11, 16'd10, '{17'h1FFFF, 17'd0, 17'd12345, 17'd30000}, 1'b0,
          '{0, 0, 0, 0}, 1'b0},
        '{6, 16'd12, 16'd11, '{17'h1FFFF, 17'd0, 17'd12345, 17'd30000}, 1'b0,
          '{0, 0, 0, 0}, 1'b0},
        '{6, 16'd13, 16'd10, '{17'd100, 17'd200, 17'd300, 17'd400}, 1'b0, '{0, 0, 0, 0}, 1'b0},
        '{6, 16'd10, 16'd13, '{17'd65536, 17'd65536, 17'd65536, 17'd0}, 1'b0,
          '{0, 0, 0, 0}, 1'b0},
        '{7, 16'd10, 16'd10, '{17'd100, 17'd200, 17'd300, 17'd400}, 1'b0, '{0, 0, 0, 0}, 1'b0},
        '{7, 16'd12, 16'd12, '{17'd100, 17'd200, 17'd300, 17'd400}, 1'b0, '{0, 0, 0, 0}, 1'b0},
        '{8, 16'd11, 16'd11, '{17'd100, 17'd200, 17'd300, 17'd400}, 1'b0, '{0, 0, 0, 0}, 1'b0},
        '{9, 16'd65535, 16'd65535, '{17'd500, 17'd500, 17'd500, 17'd500}, 1'b1,
          '{17'd12345, 17'd0, 17'd65536, 17'd65536}, 1'b1},
        '{9, 16'd65000, 16'd65535, '{17'd100, 17'd200, 17'd300, 17'd400}, 1'b1,
          '{17'd100, 17'd200, 17'd300, 17'd400}, 1'b0},
        '{9, 16'd65300, 16'd65535, '{17'd100, 17'd200, 17'd300, 17'd400}, 1'b1,
          '{17'd12345, 17'd0, 17'd65536, 17'd65536}, 1'b1},
        '{10, 16'd0, 16'd0, '{17'd65536, 17'd65536, 17'd65536, 17'd65536}, 1'b1,
          '{17'd65536, 17'd65536, 17'd65536, 17'd65536}, 1'b0}
    };

    brush_dab_pixel_blend_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_pixel_x   (i_pixel_x),
        .i_pixel_y   (i_pixel_y),
        .i_old_red   (i_old_red),
        .i_old_green (i_old_green),
        .i_old_blue  (i_old_blue),
        .i_old_alpha (i_old_alpha),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_new_red   (o_new_red),
        .o_new_green (o_new_green),
        .o_new_blue  (o_new_blue),
        .o_new_alpha (o_new_alpha),
        .o_touched   (o_touched)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [16:0] clamp_unit(input logic [16:0] v);
        return (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

    function automatic logic [16:0] mix_channel(input longint unsigned top, opa, old);
        return 17'(((top * opa) >> 16) + (((ONE_Q16 - opa) * old) >> 16));
    endfunction

    // Blend the current dab over one pixel.
    function automatic t_dab_result dab_over_pixel(input logic [15:0] x, y, input t_pix old);
        t_dab_result res;
        longint unsigned opac, hard, rad, ax, ay, d2, r2, rr, fall, opa;
        longint dx, dy;
        res.pix.red   = clamp_unit(old.red);
        res.pix.green = clamp_unit(old.green);
        res.pix.blue  = clamp_unit(old.blue);
        res.pix.alpha = clamp_unit(old.alpha);
        res.touched   = 1'b0;
        opac = clamp_unit(dab.opac);
        hard = clamp_unit(dab.hard);
        rad  = dab.rad;
        if (opac == 0 || hard == 0 || rad < MIN_RADIUS) return res;
        dx = longint'(x) * 256 + 128 - longint'($signed(dab.cx));
        dy = longint'(y) * 256 + 128 - longint'($signed(dab.cy));
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ax > rad || ay > rad) return res;
        d2 = ax * ax + ay * ay;
        r2 = rad * rad;
        if (d2 > r2) return res;
        rr = (d2 << 16) / r2;
        if (hard >= ONE_Q16) begin
            fall = ONE_Q16;
        end else if (rr < hard) begin
            fall = rr + ONE_Q16 - (rr << 16) / hard;
        end else begin
            fall = (hard * (ONE_Q16 - rr)) / (ONE_Q16 - hard);
        end
        if (fall > ONE_Q16) fall = ONE_Q16;
        opa = (opac * fall) >> 16;
        res.pix.red   = mix_channel(clamp_unit(dab.pr), opa, res.pix.red);
        res.pix.green = mix_channel(clamp_unit(dab.pg), opa, res.pix.green);
        res.pix.blue  = mix_channel(clamp_unit(dab.pb), opa, res.pix.blue);
        res.pix.alpha = 17'(opa + (((ONE_Q16 - opa) * res.pix.alpha) >> 16));
        res.touched   = 1'b1;
        return res;
    endfunction

    function automatic logic [16:0] random_level();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 2) return 17'($urandom);
        if (pick == 2) return ONE_Q16;
        if (pick == 3) return 17'd0;
        return 17'($urandom_range(0, 65536));
    endfunction

    function automatic logic [24:0] random_center();
        if ($urandom_range(0, 7) == 0) return 25'(-int'($urandom_range(1, 8388608)));
        return 25'($urandom_range(0, 16777215));
    endfunction

    function automatic t_dab_cfg random_dab();
        t_dab_cfg c;
        int unsigned pick;
        c.cx = random_center();
        c.cy = random_center();
        pick = $urandom_range(0, 9);
        if (pick < 6) c.rad = 16'($urandom_range(26, 2048));
        else if (pick < 8) c.rad = 16'($urandom_range(2049, 65535));
        else if (pick == 8) c.rad = 16'($urandom_range(0, 30));
        else c.rad = $urandom_range(0, 1) ? 16'd26 : 16'd65535;
        pick = $urandom_range(0, 9);
        if (pick == 0) c.opac = 17'd0;
        else if (pick == 1) c.opac = ONE_Q16;
        else if (pick == 2) c.opac = 17'($urandom_range(65537, 131071));
        else c.opac = 17'($urandom_range(1, 65536));
        pick = $urandom_range(0, 9);
        if (pick == 0) c.hard = 17'd0;
        else if (pick == 1) c.hard = ONE_Q16;
        else if (pick == 2) c.hard = 17'($urandom_range(65537, 131071));
        else if (pick == 3) c.hard = 17'd1;
        else if (pick == 4) c.hard = 17'd65535;
        else c.hard = 17'($urandom_range(1, 65535));
        c.pr = random_level();
        c.pg = random_level();
        c.pb = random_level();
        return c;
    endfunction

    task automatic write_reg(input logic [2:0] r, input logic [24:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= r;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    task automatic load_dab(input t_dab_cfg c);
        write_reg(CFG_CENTER_X, c.cx);
        write_reg(CFG_CENTER_Y, c.cy);
        write_reg(CFG_RADIUS, 25'(c.rad));
        write_reg(CFG_OPACITY, 25'(c.opac));
        write_reg(CFG_HARDNESS, 25'(c.hard));
        write_reg(CFG_PAINT_R, 25'(c.pr));
        write_reg(CFG_PAINT_G, 25'(c.pg));
        write_reg(CFG_PAINT_B, 25'(c.pb));
        i_cfg_we <= 1'b0;
        dab = c;
    endtask

    // Every pixel yields one result, so an empty queue means the pipeline is idle.
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_pixel(input logic [15:0] x, y, input t_pix old, input int idle_pct,
                              input t_dab_result want);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_pixel_x   <= x;
        i_pixel_y   <= y;
        i_old_red   <= old.red;
        i_old_green <= old.green;
        i_old_blue  <= old.blue;
        i_old_alpha <= old.alpha;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_pixels.push_back(want);
    endtask

    task automatic check_field(input string name, input logic [16:0] want, got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_dab_result want;
        if (i_rst_n && o_valid) begin
            if (pending_pixels.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %0d %0d %0d %0d %0d",
                         $time, o_new_red, o_new_green, o_new_blue, o_new_alpha, o_touched);
            end else begin
                want = pending_pixels.pop_front();
                check_field("new_red", want.pix.red, o_new_red);
                check_field("new_green", want.pix.green, o_new_green);
                check_field("new_blue", want.pix.blue, o_new_blue);
                check_field("new_alpha", want.pix.alpha, o_new_alpha);
                check_field("touched", 17'(want.touched), 17'(o_touched));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        t_dab_result want;
        t_dab_cfg    cfg;
        t_pix        old;
        logic [15:0] x, y;
        int          cur_cfg, idle_pct, span;
        dab     = dir_cfgs[0];
        cur_cfg = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg != cur_cfg) begin
                wait_drained();
                load_dab(dir_cfgs[dir_rows[i].cfg]);
                cur_cfg = dir_rows[i].cfg;
            end
            if (dir_rows[i].known) begin
                want.pix     = dir_rows[i].want;
                want.touched = dir_rows[i].want_touched;
            end else begin
                want = dab_over_pixel(dir_rows[i].x, dir_rows[i].y, dir_rows[i].old);
            end
            send_pixel(dir_rows[i].x, dir_rows[i].y, dir_rows[i].old, 0, want);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_drained();
            cfg = random_dab();
            load_dab(cfg);
            idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 51 : 26;
            span = int'(cfg.rad) / 256 + 2;
            repeat (PHASE_PIXELS) begin
                // Aim most pixels at the dab's bounding box, the rest anywhere.
                if ($urandom_range(0, 4) != 0) begin
                    x = 16'((int'($signed(cfg.cx)) >>> 8) + int'($urandom_range(0, 2 * span))
                            - span);
                    y = 16'((int'($signed(cfg.cy)) >>> 8) + int'($urandom_range(0, 2 * span))
                            - span);
                end else begin
                    x = 16'($urandom);
                    y = 16'($urandom);
                end
                old.red   = random_level();
                old.green = random_level();
                old.blue  = random_level();
                old.alpha = random_level();
                send_pixel(x, y, old, idle_pct, dab_over_pixel(x, y, old));
            end
        end

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
